[rtl/core/ascon_aead_engine_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Ascon AEAD engine core
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef ASCON_AEAD_ENGINE_CORE_MACROS_SVH
`define ASCON_AEAD_ENGINE_CORE_MACROS_SVH
// implication checked on every clock, off during reset
`define AAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/aae_pkg.sv]
// ----------------------------------------------------------------------------
// aae_pkg
// Types, constants and functions for the Ascon AEAD engine core.
// ----------------------------------------------------------------------------
package aae_pkg;

  localparam int STATE_BITS = 320;
  localparam int TAG_BITS   = 128;
  localparam int KEY_BITS   = 128;

  typedef enum logic [2:0] {
    FN_START_ENC = 3'd0,
    FN_START_DEC = 3'd1,
    FN_AD        = 3'd2,
    FN_MSG       = 3'd3,
    FN_FINAL     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    REG_ROUNDS_A = 3'd0,
    REG_ROUNDS_B = 3'd1,
    REG_RATE     = 3'd2,
    REG_KEY_HI   = 3'd3,
    REG_KEY_LO   = 3'd4
  } reg_idx_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IV,    // state = IV | K | N
    OP_KEY_TAIL,   // x3,x4 ^= K
    OP_AD_XOR,     // absorb AD block plus pad
    OP_PAD_TOP,    // x0 ^= top bit
    OP_DSEP,       // x4 ^= 1
    OP_MSG_XOR,    // enc/dec block, capture output, pad if partial
    OP_KEY_FIN,    // key into capacity before final permutation
    OP_ROUND,      // one permutation round
    OP_TAG         // capture tag
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] rc_idx;   // constant index for OP_ROUND
  } dp_cmd_t;

  typedef struct packed {
    logic tag_match;
  } dp_stat_t;

  function automatic logic [63:0] lead_mask(input logic [7:0] v);
    logic [63:0] m;
    m = '0;
    if (v >= 8'd64) m = '1;
    else if (v != 8'd0) m = ~(64'hFFFF_FFFF_FFFF_FFFF >> v[5:0]);
    return m;
  endfunction

  function automatic logic [3:0] sat_rounds(input logic [3:0] r);
    return (r > 4'd12) ? 4'd12 : r;
  endfunction

endpackage

[rtl/core/aae_datapath.sv]
// ----------------------------------------------------------------------------
// aae_datapath
// Sponge state, one Ascon round per cycle, absorb/squeeze and tag logic.
// ----------------------------------------------------------------------------
module aae_datapath (
  input  logic              clk,
  input  aae_pkg::dp_cmd_t  cmd,
  input  logic              rate128,
  input  logic              decrypt,
  input  logic [3:0]        rounds_a,
  input  logic [3:0]        rounds_b,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  input  logic [63:0]       d_hi,
  input  logic [63:0]       d_lo,
  input  logic [7:0]        d_bits,    // already saturated to the rate
  output logic [63:0]       res_hi,
  output logic [63:0]       res_lo,
  output aae_pkg::dp_stat_t stat
);

  logic [63:0] x_r   [5];
  logic [63:0] x_nxt [5];
  logic [63:0] res_hi_r, res_hi_nxt, res_lo_r, res_lo_nxt;
  logic [63:0] m0, m1, p0, p1;
  logic [63:0] r0, r1, r2, r3, r4, t0, t1, t2, t3, t4;
  logic [7:0]  rc;

  assign m0 = aae_pkg::lead_mask(d_bits);
  assign m1 = rate128 ? aae_pkg::lead_mask((d_bits > 8'd64) ? d_bits - 8'd64 : 8'd0) : '0;
  // pad bit at position d_bits when the block is short of the rate
  assign p0 = (d_bits < 8'd64) ? (64'h8000_0000_0000_0000 >> d_bits[5:0]) : '0;
  assign p1 = (rate128 && d_bits >= 8'd64 && d_bits < 8'd128)
              ? (64'h8000_0000_0000_0000 >> d_bits[5:0]) : '0;

  assign rc = {4'd15 - cmd.rc_idx, cmd.rc_idx};

  always_comb begin
    r0 = x_r[0] ^ x_r[4];
    r4 = x_r[4] ^ x_r[3];
    r2 = x_r[2] ^ {56'd0, rc} ^ x_r[1];
    r1 = x_r[1];
    r3 = x_r[3];
    t0 = ~r0 & r1; t1 = ~r1 & r2; t2 = ~r2 & r3; t3 = ~r3 & r4; t4 = ~r4 & r0;
    r0 = r0 ^ t1; r1 = r1 ^ t2; r2 = r2 ^ t3; r3 = r3 ^ t4; r4 = r4 ^ t0;
    r1 = r1 ^ r0; r3 = r3 ^ r2; r0 = r0 ^ r4; r2 = ~r2;
  end

  function automatic logic [63:0] ror(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  always_comb begin
    for (int i = 0; i < 5; i++) x_nxt[i] = x_r[i];
    res_hi_nxt = res_hi_r;
    res_lo_nxt = res_lo_r;
    unique case (cmd.op)
      aae_pkg::OP_LOAD_IV: begin
        x_nxt[0] = {8'(aae_pkg::KEY_BITS), rate128 ? 8'd128 : 8'd64,
                    4'd0, aae_pkg::sat_rounds(rounds_a),
                    4'd0, aae_pkg::sat_rounds(rounds_b), 32'd0};
        x_nxt[1] = key_high;
        x_nxt[2] = key_low;
        x_nxt[3] = d_hi;
        x_nxt[4] = d_lo;
      end
      aae_pkg::OP_KEY_TAIL: begin
        x_nxt[3] = x_r[3] ^ key_high;
        x_nxt[4] = x_r[4] ^ key_low;
      end
      aae_pkg::OP_AD_XOR: begin
        x_nxt[0] = x_r[0] ^ (d_hi & m0) ^ p0;
        x_nxt[1] = x_r[1] ^ (d_lo & m1) ^ p1;
      end
      aae_pkg::OP_PAD_TOP: x_nxt[0] = x_r[0] ^ 64'h8000_0000_0000_0000;
      aae_pkg::OP_DSEP:    x_nxt[4] = x_r[4] ^ 64'd1;
      aae_pkg::OP_MSG_XOR: begin
        if (decrypt) begin
          res_hi_nxt = (x_r[0] ^ d_hi) & m0;
          res_lo_nxt = (x_r[1] ^ d_lo) & m1;
          x_nxt[0] = x_r[0] ^ ((x_r[0] ^ d_hi) & m0) ^ p0;
          x_nxt[1] = x_r[1] ^ ((x_r[1] ^ d_lo) & m1) ^ p1;
        end else begin
          res_hi_nxt = (x_r[0] ^ d_hi) & m0;
          res_lo_nxt = (x_r[1] ^ d_lo) & m1;
          x_nxt[0] = x_r[0] ^ (d_hi & m0) ^ p0;
          x_nxt[1] = x_r[1] ^ (d_lo & m1) ^ p1;
        end
      end
      aae_pkg::OP_KEY_FIN: begin
        if (rate128) begin
          x_nxt[2] = x_r[2] ^ key_high;
          x_nxt[3] = x_r[3] ^ key_low;
        end else begin
          x_nxt[1] = x_r[1] ^ key_high;
          x_nxt[2] = x_r[2] ^ key_low;
        end
      end
      aae_pkg::OP_ROUND: begin
        x_nxt[0] = r0 ^ ror(r0, 19) ^ ror(r0, 28);
        x_nxt[1] = r1 ^ ror(r1, 61) ^ ror(r1, 39);
        x_nxt[2] = r2 ^ ror(r2, 1)  ^ ror(r2, 6);
        x_nxt[3] = r3 ^ ror(r3, 10) ^ ror(r3, 17);
        x_nxt[4] = r4 ^ ror(r4, 7)  ^ ror(r4, 41);
      end
      aae_pkg::OP_TAG: begin
        res_hi_nxt = x_r[3] ^ key_high;
        res_lo_nxt = x_r[4] ^ key_low;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) x_r[i] <= x_nxt[i];
    res_hi_r <= res_hi_nxt;
    res_lo_r <= res_lo_nxt;
  end

  assign res_hi = res_hi_r;
  assign res_lo = res_lo_r;
  assign stat.tag_match = (res_hi_r == d_hi) && (res_lo_r == d_lo);

endmodule

[rtl/core/aae_ctrl.sv]
// ----------------------------------------------------------------------------
// aae_ctrl
// Sequencer: phase tracking, round counting and output handshake.
// ----------------------------------------------------------------------------
module aae_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [2:0]        func,
  input  logic [7:0]        v_bits,   // saturated to the rate
  input  logic              last,
  input  logic              rate128,
  input  logic [3:0]        rounds_a,
  input  logic [3:0]        rounds_b,
  input  aae_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              busy,
  output logic              decrypt,
  output aae_pkg::dp_cmd_t  cmd,
  output logic              out_valid,
  output logic              out_kind,
  output logic              out_tag_ok,
  output logic [7:0]        out_bits
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_AD_EMPTY, PH_AD_OPEN, PH_MSG_OPEN, PH_MSG_CLOSED
  } phase_t;

  // each job is a list of micro-steps; an enumerated state marks the current one
  typedef enum logic [3:0] {
    S_IDLE, S_IV, S_INIT_RND, S_KEY_TAIL, S_AD_XOR, S_AD_RND, S_PAD_TOP,
    S_CLOSE_RND, S_DSEP, S_MSG_XOR, S_MSG_RND, S_MSG_PAD, S_FIN_KEY,
    S_FIN_RND, S_TAG, S_OUT
  } st_t;

  st_t         st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic        dec_r, dec_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  tot_r, tot_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [7:0]  v_r, v_nxt;
  logic        last_r, last_nxt;
  logic        kind_r, kind_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [3:0]  ra, rb;
  logic [7:0]  rate;

  assign ra   = aae_pkg::sat_rounds(rounds_a);
  assign rb   = aae_pkg::sat_rounds(rounds_b);
  assign rate = rate128 ? 8'd128 : 8'd64;

  // which state follows once associated data is closed, per job
  function automatic st_t after_close(input logic [2:0] f);
    return (f == aae_pkg::FN_FINAL) ? S_FIN_KEY : S_MSG_XOR;
  endfunction

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; dec_nxt = dec_r; cnt_nxt = cnt_r; tot_nxt = tot_r;
    func_nxt = func_r; v_nxt = v_r; last_nxt = last_r;
    kind_nxt = kind_r; ok_nxt = ok_r; bits_nxt = bits_r;
    cmd.op = aae_pkg::OP_NONE;
    cmd.rc_idx = 4'd12 - tot_r + cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt = func; v_nxt = v_bits; last_nxt = last;
          unique case (func)
            aae_pkg::FN_START_ENC, aae_pkg::FN_START_DEC: begin
              dec_nxt = func[0]; st_nxt = S_IV;
            end
            aae_pkg::FN_AD: begin
              if (ph_r == PH_AD_EMPTY && v_bits == 8'd0) st_nxt = S_DSEP;
              else if (ph_r == PH_AD_EMPTY || ph_r == PH_AD_OPEN) st_nxt = S_AD_XOR;
            end
            aae_pkg::FN_MSG: begin
              if (ph_r == PH_AD_OPEN) st_nxt = S_PAD_TOP;
              else if (ph_r == PH_AD_EMPTY) st_nxt = S_DSEP;
              else if (ph_r == PH_MSG_OPEN) st_nxt = S_MSG_XOR;
            end
            aae_pkg::FN_FINAL: begin
              if (ph_r == PH_AD_OPEN) st_nxt = S_PAD_TOP;
              else if (ph_r == PH_AD_EMPTY) st_nxt = S_DSEP;
              else if (ph_r == PH_MSG_OPEN) st_nxt = S_MSG_PAD;
              else if (ph_r == PH_MSG_CLOSED) st_nxt = S_FIN_KEY;
            end
            default: ;
          endcase
        end
      end
      S_IV: begin
        cmd.op = aae_pkg::OP_LOAD_IV;
        cnt_nxt = '0; tot_nxt = ra;
        st_nxt = (ra == 4'd0) ? S_KEY_TAIL : S_INIT_RND;
      end
      S_INIT_RND: begin
        cmd.op = aae_pkg::OP_ROUND;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r + 4'd1 == tot_r) st_nxt = S_KEY_TAIL;
      end
      S_KEY_TAIL: begin
        cmd.op = aae_pkg::OP_KEY_TAIL;
        ph_nxt = PH_AD_EMPTY; st_nxt = S_IDLE;
      end
      S_AD_XOR: begin
        cmd.op = aae_pkg::OP_AD_XOR;
        cnt_nxt = '0; tot_nxt = rb;
        st_nxt = (rb == 4'd0) ? S_AD_RND : S_AD_RND;
      end
      S_AD_RND: begin
        if (cnt_r != tot_r) begin
          cmd.op = aae_pkg::OP_ROUND;
          cnt_nxt = cnt_r + 4'd1;
        end
        if (cnt_r == tot_r || cnt_r + 4'd1 == tot_r) begin
          if (v_r < rate || last_r) st_nxt = S_DSEP;
          else begin ph_nxt = PH_AD_OPEN; st_nxt = S_IDLE; end
          // full last block still needs a padding-only block
          if (v_r >= rate && last_r) st_nxt = S_PAD_TOP;
          if (v_r >= rate && last_r) ph_nxt = PH_AD_OPEN;
          if (v_r >= rate && last_r) func_nxt = aae_pkg::FN_AD;
        end
      end
      S_PAD_TOP: begin
        cmd.op = aae_pkg::OP_PAD_TOP;
        cnt_nxt = '0; tot_nxt = rb;
        st_nxt = S_CLOSE_RND;
      end
      S_CLOSE_RND: begin
        if (cnt_r != tot_r) begin
          cmd.op = aae_pkg::OP_ROUND;
          cnt_nxt = cnt_r + 4'd1;
        end
        if (cnt_r == tot_r || cnt_r + 4'd1 == tot_r) st_nxt = S_DSEP;
      end
      S_DSEP: begin
        cmd.op = aae_pkg::OP_DSEP;
        ph_nxt = PH_MSG_OPEN;
        if (func_r == aae_pkg::FN_AD) st_nxt = S_IDLE;
        else if (func_r == aae_pkg::FN_FINAL) st_nxt = S_MSG_PAD;
        else st_nxt = after_close(func_r);
      end
      S_MSG_XOR: begin
        cmd.op = aae_pkg::OP_MSG_XOR;
        kind_nxt = 1'b0; ok_nxt = 1'b0; bits_nxt = v_r;
        cnt_nxt = '0; tot_nxt = rb;
        if (v_r < rate) begin
          ph_nxt = PH_MSG_CLOSED; st_nxt = S_OUT;
        end else st_nxt = S_MSG_RND;
      end
      S_MSG_RND: begin
        if (cnt_r != tot_r) begin
          cmd.op = aae_pkg::OP_ROUND;
          cnt_nxt = cnt_r + 4'd1;
        end
        if (cnt_r == tot_r || cnt_r + 4'd1 == tot_r) begin
          if (last_r) begin
            func_nxt = aae_pkg::FN_MSG; st_nxt = S_MSG_PAD;
          end else st_nxt = S_OUT;
        end
      end
      S_MSG_PAD: begin
        cmd.op = aae_pkg::OP_PAD_TOP;
        ph_nxt = PH_MSG_CLOSED;
        st_nxt = (func_r == aae_pkg::FN_FINAL) ? S_FIN_KEY : S_OUT;
      end
      S_FIN_KEY: begin
        cmd.op = aae_pkg::OP_KEY_FIN;
        cnt_nxt = '0; tot_nxt = ra;
        st_nxt = (ra == 4'd0) ? S_TAG : S_FIN_RND;
      end
      S_FIN_RND: begin
        cmd.op = aae_pkg::OP_ROUND;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r + 4'd1 == tot_r) st_nxt = S_TAG;
      end
      S_TAG: begin
        cmd.op = aae_pkg::OP_TAG;
        kind_nxt = 1'b1; bits_nxt = 8'(aae_pkg::TAG_BITS);
        ph_nxt = PH_IDLE; st_nxt = S_OUT;
        func_nxt = aae_pkg::FN_FINAL;
      end
      S_OUT: begin
        // tag compare sees the registered tag now
        ok_nxt = kind_r & dec_r & stat.tag_match;
        if (out_ready && out_valid) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_IDLE; dec_r <= 1'b0;
      cnt_r <= '0; tot_r <= '0; func_r <= '0; v_r <= '0; last_r <= 1'b0;
      kind_r <= 1'b0; ok_r <= 1'b0; bits_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; dec_r <= dec_nxt;
      cnt_r <= cnt_nxt; tot_r <= tot_nxt; func_r <= func_nxt; v_r <= v_nxt;
      last_r <= last_nxt; kind_r <= kind_nxt; ok_r <= ok_nxt; bits_r <= bits_nxt;
    end
  end

  assign busy       = (st_r != S_IDLE);
  assign decrypt    = dec_r;
  assign out_valid  = (st_r == S_OUT);
  assign out_kind   = kind_r;
  assign out_tag_ok = kind_r & dec_r & stat.tag_match;
  assign out_bits   = bits_r;

endmodule

[rtl/core/ascon_aead_engine_core.sv]
// Ascon-128 AEAD engine core.
// Input channel in_*: tdata = {valid_bits, data_low, data_high}, tuser = func,
// tlast = last. A start item (encrypt/decrypt) carries the nonce; associated
// data and message blocks follow, then a finalise item (expected tag in tdata
// for decryption).
// Output channel out_*: tdata = {out_bits, out_low, out_high}, tuser =
// {tag_ok, result_kind}. Message items and finalise give one beat each.
// With a zero b each b round phase still passes through its round state
// without issuing a round. Rounds run one per cycle in the shared round unit;
// one item is in work at a time.
// Payload (tdata) is held for the whole item; in_tready is low while busy.
// Reset (rst_n low, synchronous) returns to idle with default registers.
// A stalled output holds the result and the engine until out_tready rises.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata; the user must
// write it only while idle, as the core does not enforce this itself.
module ascon_aead_engine_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // data_high, data_low, valid_bits
  input  logic [2:0]   in_tuser,   // func
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // out_high, out_low, out_bits
  output logic [1:0]   out_tuser,  // result_kind, tag_ok
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [63:0]  cfg_wdata
);

  logic [3:0]  ra_r, rb_r;
  logic [7:0]  rate_r;
  logic [63:0] kh_r, kl_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0]  vb, vb_sat;
  logic        rate128, fire, busy, dec, kind, ok;
  logic [7:0]  obits;
  logic [63:0] rh, rl;
  aae_pkg::dp_cmd_t  cmd;
  aae_pkg::dp_stat_t stat;
  logic [7:0]  vb_r;

  assign rate128 = (rate_r == 8'd128);
  assign vb      = in_tdata[135:128];
  assign vb_sat  = (vb > (rate128 ? 8'd128 : 8'd64)) ? (rate128 ? 8'd128 : 8'd64) : vb;
  assign in_tready = !busy;
  assign fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r <= 4'd12; rb_r <= 4'd6; rate_r <= 8'd64; kh_r <= '0; kl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        aae_pkg::REG_ROUNDS_A: ra_r   <= cfg_wdata[3:0];
        aae_pkg::REG_ROUNDS_B: rb_r   <= cfg_wdata[3:0];
        aae_pkg::REG_RATE:     rate_r <= cfg_wdata[7:0];
        aae_pkg::REG_KEY_HI:   kh_r   <= cfg_wdata;
        aae_pkg::REG_KEY_LO:   kl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the beat payload for the whole item
  always_ff @(posedge clk) begin
    if (fire) begin
      hi_r <= in_tdata[63:0];
      lo_r <= in_tdata[127:64];
      vb_r <= vb_sat;
    end
  end

  aae_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(fire), .func(in_tuser), .v_bits(vb_sat), .last(in_tlast),
    .rate128, .rounds_a(ra_r), .rounds_b(rb_r), .stat, .out_ready(out_tready),
    .busy, .decrypt(dec), .cmd, .out_valid(out_tvalid), .out_kind(kind),
    .out_tag_ok(ok), .out_bits(obits)
  );

  aae_datapath u_dp (
    .clk, .cmd, .rate128, .decrypt(dec), .rounds_a(ra_r), .rounds_b(rb_r),
    .key_high(kh_r), .key_low(kl_r), .d_hi(hi_r), .d_lo(lo_r), .d_bits(vb_r),
    .res_hi(rh), .res_lo(rl), .stat
  );

  assign out_tdata = {obits, rl, rh};
  assign out_tuser = {ok, kind};

endmodule

[rtl/core/aae_checker.sv]
// ----------------------------------------------------------------------------
// aae_checker
// Port-level checks on the engine core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascon_aead_engine_core_macros.svh"
module aae_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser
);
  `AAE_ASSERT_IMP(a_no_take_while_out, clk, rst_n, out_tvalid, !in_tready, "input taken while result pending")
  `AAE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped under stall")
  `AAE_ASSERT_IMP(a_tag_bits, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[135:128] == 8'd128, "tag beat not 128 bits")
  `AAE_ASSERT_IMP(a_ok_only_tag, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0], "tag_ok on message beat")
endmodule

bind ascon_aead_engine_core aae_checker u_aae_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
